// ===== hdl/keyed_sum_max_count_table_defines.svh =====
// Assertion macros shared by the keyed_sum_max_count_table RTL.
`ifndef KEYED_SUM_MAX_COUNT_TABLE_DEFINES_SVH
`define KEYED_SUM_MAX_COUNT_TABLE_DEFINES_SVH

`ifndef SYNTH
`define KST_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("kst assertion failed");
`define KST_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("kst forbidden condition seen");
`else
`define KST_ASSERT(label, clk, rst, prop)
`define KST_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== hdl/kst_pkg.sv =====
// Types and constants for the keyed sum/max/count table.
package kst_pkg;

  localparam int TOTAL_W = 64;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 4;
  localparam int KEY_W   = 8;
  localparam int OIDX_W  = 3;

  localparam logic [1:0] ACT_DEPOSIT = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RESET = 4'd8;

  localparam logic [TOTAL_W-1:0] TOTAL_ALL_ONES = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [1:0]         action;
    logic [KEY_W-1:0]   entry_index;
    logic [TOTAL_W-1:0] amount;
  } in_t;

  typedef struct packed {
    logic               status;
    logic [TOTAL_W-1:0] entry_total;
    logic [TOTAL_W-1:0] entry_largest;
    logic [COUNT_W-1:0] entry_count;
    logic [TOTAL_W-1:0] highest_total;
    logic [OIDX_W-1:0]  highest_index;
    logic [TOTAL_W-1:0] lowest_total;
    logic [OIDX_W-1:0]  lowest_index;
  } out_t;

  // One table row as stored in memory.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] largest;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

// ===== hdl/kst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/keyed_sum_max_count_table.sv =====
// Keyed table of ENTRIES rows (total, largest amount, deposit count) held in one
// RAM with a single read port. A deposit or read is first read from the table;
// a deposit is then modified and written back, and then the result is delivered. An
// item with a bad index or an unknown action skips the read and goes straight to
// delivery. A query walks the entries in use through the read port, one per
// cycle; with no entries in use it reads no rows. One item is in work at a time;
// the next is accepted as soon as the previous result sits in the output
// register, even if it has not been taken yet. The table reads as all zero after
// reset through per-row valid bits, so no clearing pass is needed. entries_in_use
// is written through the cfg port; the user must write it only while the block is
// idle, which the block does not enforce. Values above ENTRIES act as ENTRIES.
`include "keyed_sum_max_count_table_defines.svh"

module keyed_sum_max_count_table
  import kst_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SC_W  = IDX_W + 1;
  localparam int CMP_W = 9;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [CFG_W-1:0]   entries_in_use;
  logic [CFG_W-1:0]   eff_n;
  in_t                req;
  out_t               res;
  out_t               res_init;
  logic [ENTRIES-1:0] entry_valid;
  logic [SC_W-1:0]    scan_cnt;
  logic               pend_valid;
  logic [IDX_W-1:0]   pend_idx;

  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  entry_t             ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  entry_t             ram_rd_data;

  logic               accept;
  logic               load_out;
  logic               idx_bad;
  logic               scan_more;
  logic [IDX_W-1:0]   req_addr;
  entry_t             cur;
  entry_t             upd;
  logic [TOTAL_W-1:0] scan_total;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);

  assign eff_n     = (CMP_W'(entries_in_use) < CMP_W'(ENTRIES)) ? entries_in_use
                                                                 : CFG_W'(ENTRIES);
  assign idx_bad   = CMP_W'(in_data.entry_index) >= CMP_W'(eff_n);
  assign scan_more = CMP_W'(scan_cnt) < CMP_W'(eff_n);
  assign req_addr  = req.entry_index[IDX_W-1:0];

  // Rows never written read as zero.
  assign cur = entry_valid[req_addr] ? ram_rd_data : '0;

  always_comb begin
    upd.total   = cur.total + req.amount;
    upd.largest = (cur.largest < req.amount) ? req.amount : cur.largest;
    upd.count   = cur.count + COUNT_W'(1);
  end

  assign scan_total = entry_valid[pend_idx] ? ram_rd_data.total : '0;

  // Starting result for the beat being accepted.
  always_comb begin
    res_init = '0;
    case (in_data.action)
      ACT_DEPOSIT, ACT_READ: res_init.status = idx_bad ? STATUS_ERR : STATUS_OK;
      ACT_QUERY:             res_init.lowest_total = TOTAL_ALL_ONES;
      default:               res_init.status = STATUS_ERR;
    endcase
  end

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = in_data.entry_index[IDX_W-1:0];
    if (accept) begin
      ram_rd_en = (in_data.action == ACT_DEPOSIT || in_data.action == ACT_READ) && !idx_bad;
    end else if (state == ST_SCAN) begin
      ram_rd_en   = scan_more;
      ram_rd_addr = scan_cnt[IDX_W-1:0];
    end
  end

  assign ram_wr_en   = (state == ST_MOD) && (req.action == ACT_DEPOSIT);
  assign ram_wr_addr = req_addr;
  assign ram_wr_data = upd;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_DEPOSIT, ACT_READ: state_next = idx_bad ? ST_DONE : ST_MOD;
            ACT_QUERY:             state_next = ST_SCAN;
            default:               state_next = ST_DONE;
          endcase
        end
      end
      ST_MOD:  state_next = ST_DONE;
      ST_SCAN: begin
        if (!scan_more && !pend_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entries_in_use <= ENTRIES_IN_USE_RESET;
      entry_valid    <= '0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        entries_in_use <= cfg_data;
      end
      if (ram_wr_en) begin
        entry_valid[ram_wr_addr] <= 1'b1;
      end
      pend_valid <= (state == ST_SCAN) && scan_more;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= in_data;
      res      <= res_init;
      scan_cnt <= '0;
    end
    if (state == ST_MOD) begin
      if (req.action == ACT_DEPOSIT) begin
        res.entry_total   <= upd.total;
        res.entry_largest <= upd.largest;
        res.entry_count   <= upd.count;
      end else begin
        res.entry_total   <= cur.total;
        res.entry_largest <= cur.largest;
        res.entry_count   <= cur.count;
      end
    end
    if (state == ST_SCAN) begin
      if (scan_more) begin
        pend_idx <= scan_cnt[IDX_W-1:0];
        scan_cnt <= scan_cnt + SC_W'(1);
      end
      // Strict compares keep the first entry on ties.
      if (pend_valid) begin
        if (scan_total > res.highest_total) begin
          res.highest_total <= scan_total;
          res.highest_index <= OIDX_W'(pend_idx);
        end
        if (scan_total < res.lowest_total) begin
          res.lowest_total <= scan_total;
          res.lowest_index <= OIDX_W'(pend_idx);
        end
      end
    end
    if (load_out) begin
      out_data <= res;
    end
  end

  kst_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  `KST_ASSERT(a_load_free_slot, clk, rst, load_out |-> (!out_valid || out_ready))
  `KST_ASSERT(a_bad_index_no_write, clk, rst, (accept && idx_bad && (in_data.action == ACT_DEPOSIT)) |=> !ram_wr_en)
  `KST_NEVER(a_scan_overrun, clk, rst, (state == ST_SCAN) && (CMP_W'(scan_cnt) > CMP_W'(eff_n)))
  `KST_NEVER(a_read_while_write, clk, rst, ram_wr_en && ram_rd_en)

endmodule
